// File: hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the csv stream tokenizer: parse modes,
// result kinds, the result record and the per-byte result bundle.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int MAX_COLUMNS   = 256;
    localparam int SPACE_RUN_MAX = 65535;
    localparam int COUNT_BITS    = 24;
    localparam int MAX_RES       = 4;
    localparam int QUEUE_DEPTH   = 4;

    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int RUN_W  = $clog2(SPACE_RUN_MAX + 1);
    localparam int CNT_W  = $clog2(MAX_RES + 1);
    localparam int RIDX_W = $clog2(MAX_RES);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TEXT_HIGH = 8'h7E;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] SEP_RESET     = 8'h2C;
    localparam logic [7:0] COMMENT_RESET = 8'h23;

    // configuration register indexes
    localparam logic CFG_SEPARATOR = 1'b0;
    localparam logic CFG_COMMENT   = 1'b1;

    // input item kinds
    localparam logic IN_DATA = 1'b0;
    localparam logic IN_END  = 1'b1;

    typedef enum logic [3:0] {
        M_LINE, M_SPACES, M_COMMENT, M_FSTART, M_PLAIN, M_QUOTED,
        M_QCLOSE, M_ESCAPE, M_AFTER, M_WANT_LF, M_HALT
    } t_mode;

    typedef enum logic [2:0] {
        K_FIELD_BYTE, K_FIELD_END, K_RECORD_END, K_ROW_DROPPED,
        K_COMMENT, K_ABORT, K_SPACE_RUN, K_FINAL
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            data;
        logic [RUN_W-1:0]      run;
        logic                  ovf;
        logic [COL_W-1:0]      fc;
        logic [COL_W-1:0]      hdr;
        logic                  mism;
        logic [COUNT_BITS-1:0] line;
        logic [COUNT_BITS-1:0] rows;
        logic                  good;
        logic                  empty_in;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        t_res [MAX_RES-1:0] res;
    } t_bnd;

    typedef struct packed {
        t_mode                 mode;
        logic [RUN_W-1:0]      space_run;
        logic                  space_lost;
        logic                  ffe;
        logic                  fhb;
        logic [COL_W-1:0]      fir;
        logic [COL_W-1:0]      hw;
        logic [COUNT_BITS-1:0] line;
        logic [COUNT_BITS-1:0] rows;
        logic                  good;
        logic                  seen;
    } t_st;

endpackage

// File: hw/rtl/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Byte parser: takes one input item per cycle while accepted, updates the parse
// state and builds the bundle of up to four result items that the byte causes.
// ----------------------------------------------------------------------------
module cst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_in_byte,
    output cst_pkg::t_bnd     o_bnd,
    output logic              o_bnd_wr
);
    import cst_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [7:0] r_sep;
    logic [7:0] r_cmt;
    t_st        r_st;
    t_st        n_st;
    t_bnd       n_bnd;

    // parse state after reset
    function automatic t_st st_reset();
        t_st s;
        s      = '0;
        s.mode = M_LINE;
        s.line = COUNT_BITS'(1);
        s.good = 1'b1;
        return s;
    endfunction

    // append one result, snapshotting the running counters
    function automatic void push_res(input t_st s, inout t_bnd r, input t_kind k,
                                     input logic [7:0] b, input logic [RUN_W-1:0] run,
                                     input logic ovf, input logic [COL_W-1:0] fc,
                                     input logic mism, input logic ag, input logic ei);
        t_res e;
        e.kind     = k;
        e.data     = b;
        e.run      = run;
        e.ovf      = ovf;
        e.fc       = fc;
        e.hdr      = s.hw;
        e.mism     = mism;
        e.line     = s.line;
        e.rows     = s.rows;
        e.good     = ag;
        e.empty_in = ei;
        if (r.cnt < CNT_W'(MAX_RES)) begin
            r.res[r.cnt[RIDX_W-1:0]] = e;
            r.cnt = r.cnt + CNT_W'(1);
        end
    endfunction

    function automatic void field_byte(inout t_st s, inout t_bnd r, input logic [7:0] b);
        s.fhb = 1'b1;
        if (!s.ffe) begin
            push_res(s, r, K_FIELD_BYTE, b, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        end
    endfunction

    function automatic void end_field(inout t_st s, inout t_bnd r);
        if (s.fir == '0) begin
            s.ffe = !s.fhb;
        end
        if (!s.ffe) begin
            push_res(s, r, K_FIELD_END, 8'h00, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        end
        if (s.fir < COL_W'(MAX_COLUMNS)) begin
            s.fir = s.fir + COL_W'(1);
        end
        s.fhb = 1'b0;
    endfunction

    function automatic void end_record(inout t_st s, inout t_bnd r);
        logic mism;
        mism = 1'b0;
        if (s.ffe) begin
            push_res(s, r, K_ROW_DROPPED, 8'h00, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        end else begin
            if (s.hw == '0) begin
                s.hw = s.fir;
            end else if (s.fir != s.hw) begin
                mism   = 1'b1;
                s.good = 1'b0;
            end
            if (s.rows != CNT_MAX) begin
                s.rows = s.rows + COUNT_BITS'(1);
            end
            push_res(s, r, K_RECORD_END, 8'h00, '0, 1'b0, s.fir, mism, 1'b0, 1'b0);
        end
        s.fir = '0;
        s.ffe = 1'b0;
        s.fhb = 1'b0;
    endfunction

    function automatic void abort_parse(inout t_st s, inout t_bnd r);
        s.good = 1'b0;
        push_res(s, r, K_ABORT, 8'h00, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        s.mode = M_HALT;
    endfunction

    function automatic void line_done(inout t_st s);
        if (s.line != CNT_MAX) begin
            s.line = s.line + COUNT_BITS'(1);
        end
        s.mode = M_LINE;
    endfunction

    function automatic void after_field(inout t_st s, inout t_bnd r, input logic [7:0] b,
                                        input logic [7:0] sep);
        if (b == sep) begin
            s.mode = M_FSTART;
        end else if (b == CH_LF) begin
            end_record(s, r);
            line_done(s);
        end else if (b == CH_CR) begin
            end_record(s, r);
            s.mode = M_WANT_LF;
        end else begin
            end_record(s, r);
            abort_parse(s, r);
        end
    endfunction

    function automatic logic plain_byte(input logic [7:0] b, input logic [7:0] sep);
        return (b != sep) && (b >= CH_SPACE) && (b <= CH_TEXT_HIGH);
    endfunction

    function automatic void field_start(inout t_st s, inout t_bnd r, input logic [7:0] b,
                                        input logic [7:0] sep);
        if (b == sep) begin
            end_field(s, r);
            after_field(s, r, b, sep);
        end else if (b == CH_QUOTE) begin
            s.mode = M_QUOTED;
        end else if (plain_byte(b, sep)) begin
            field_byte(s, r, b);
            s.mode = M_PLAIN;
        end else begin
            end_field(s, r);
            after_field(s, r, b, sep);
        end
    endfunction

    function automatic void plain(inout t_st s, inout t_bnd r, input logic [7:0] b,
                                  input logic [7:0] sep);
        if (plain_byte(b, sep)) begin
            field_byte(s, r, b);
        end else begin
            end_field(s, r);
            after_field(s, r, b, sep);
        end
    endfunction

    function automatic void flush_spaces(inout t_st s, inout t_bnd r, input logic [7:0] sep);
        if (s.space_run != '0) begin
            if (sep == CH_SPACE) begin
                s.ffe  = 1'b1;
                s.fir  = COL_W'(1);
                s.mode = M_FSTART;
            end else begin
                push_res(s, r, K_SPACE_RUN, 8'h00, s.space_run, s.space_lost, '0,
                         1'b0, 1'b0, 1'b0);
                s.fhb  = 1'b1;
                s.mode = M_PLAIN;
            end
        end else begin
            s.mode = M_FSTART;
        end
        s.space_run  = '0;
        s.space_lost = 1'b0;
    endfunction

    function automatic void line_byte(inout t_st s, inout t_bnd r, input logic [7:0] b,
                                      input logic [7:0] sep, input logic [7:0] cmt);
        if (b == CH_SPACE) begin
            if (s.space_run < RUN_W'(SPACE_RUN_MAX)) begin
                s.space_run = s.space_run + RUN_W'(1);
            end else begin
                s.space_lost = 1'b1;
            end
            s.mode = M_SPACES;
        end else if (b == cmt) begin
            s.space_run  = '0;
            s.space_lost = 1'b0;
            push_res(s, r, K_COMMENT, 8'h00, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
            if (b == CH_LF) begin
                line_done(s);
            end else begin
                s.mode = M_COMMENT;
            end
        end else begin
            flush_spaces(s, r, sep);
            if (s.mode == M_PLAIN) begin
                plain(s, r, b, sep);
            end else begin
                field_start(s, r, b, sep);
            end
        end
    endfunction

    function automatic void quoted(inout t_st s, inout t_bnd r, input logic [7:0] b,
                                   input logic [7:0] sep);
        if (b == CH_QUOTE) begin
            s.mode = M_QCLOSE;
        end else if (b == CH_BACKSLASH) begin
            s.mode = M_ESCAPE;
        end else if ((b >= CH_SPACE && b <= CH_TEXT_HIGH) || b == sep ||
                     b == CH_CR || b == CH_LF) begin
            field_byte(s, r, b);
        end else begin
            end_field(s, r);
            s.mode = M_AFTER;
        end
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
            r_cmt <= COMMENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SEPARATOR: r_sep <= i_cfg_data;
                CFG_COMMENT:   r_cmt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next parse state and result bundle for the offered item
    always_comb begin
        n_st  = r_st;
        n_bnd = '0;
        if (i_kind == IN_END) begin
            case (n_st.mode)
                M_SPACES: begin
                    flush_spaces(n_st, n_bnd, r_sep);
                    end_field(n_st, n_bnd);
                    end_record(n_st, n_bnd);
                end
                M_FSTART, M_PLAIN, M_QUOTED, M_QCLOSE, M_ESCAPE: begin
                    end_field(n_st, n_bnd);
                    end_record(n_st, n_bnd);
                end
                M_AFTER:   end_record(n_st, n_bnd);
                M_WANT_LF: abort_parse(n_st, n_bnd);
                default: ;
            endcase
            push_res(n_st, n_bnd, K_FINAL, 8'h00, '0, 1'b0, '0, 1'b0, n_st.good,
                     !n_st.seen);
            n_st.mode = M_HALT;
        end else begin
            n_st.seen = 1'b1;
            case (n_st.mode)
                M_LINE, M_SPACES: line_byte(n_st, n_bnd, i_in_byte, r_sep, r_cmt);
                M_COMMENT: begin
                    if (i_in_byte == CH_LF) begin
                        line_done(n_st);
                    end
                end
                M_FSTART: field_start(n_st, n_bnd, i_in_byte, r_sep);
                M_PLAIN:  plain(n_st, n_bnd, i_in_byte, r_sep);
                M_QUOTED: quoted(n_st, n_bnd, i_in_byte, r_sep);
                M_QCLOSE: begin
                    if (i_in_byte == CH_QUOTE) begin
                        field_byte(n_st, n_bnd, CH_QUOTE);
                        n_st.mode = M_QUOTED;
                    end else begin
                        end_field(n_st, n_bnd);
                        after_field(n_st, n_bnd, i_in_byte, r_sep);
                    end
                end
                M_ESCAPE: begin
                    field_byte(n_st, n_bnd, i_in_byte);
                    n_st.mode = M_QUOTED;
                end
                M_AFTER: after_field(n_st, n_bnd, i_in_byte, r_sep);
                M_WANT_LF: begin
                    if (i_in_byte == CH_LF) begin
                        line_done(n_st);
                    end else begin
                        abort_parse(n_st, n_bnd);
                    end
                end
                default: ;
            endcase
        end
    end

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= st_reset();
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

    assign o_bnd    = n_bnd;
    assign o_bnd_wr = i_accept && (n_bnd.cnt != '0);

endmodule

// File: hw/rtl/cst_queue.sv
// ----------------------------------------------------------------------------
// cst_queue
// Bundle queue between parser and output, and the unpacker that hands out
// the result items of the head bundle one per cycle while pop is held.
// ----------------------------------------------------------------------------
module cst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cst_pkg::t_bnd i_bnd,
    input  logic          i_wr,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output cst_pkg::t_res o_res
);
    import cst_pkg::*;

    t_bnd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [RIDX_W-1:0] r_idx;
    logic              head_done;
    logic              deq;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_res     = r_mem[r_rd].res[r_idx];
    assign head_done = ({1'b0, r_idx} + CNT_W'(1)) == r_mem[r_rd].cnt;
    assign deq       = i_pop && !o_empty && head_done;

    // bundle storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_bnd;
        end
    end

    // pointers, fill count and item index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop && !o_empty) begin
                if (head_done) begin
                    r_rd  <= r_rd + QPTR_W'(1);
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + RIDX_W'(1);
                end
            end
            if (i_wr && !deq) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_wr && deq) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/csv_stream_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_unit
// CSV tokenizer: one text byte per item in, field bytes, space runs, field
// and record ends, comment, drop, abort and final status items out.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------------------
//  input     | push / full       | i_kind, i_in_byte
//  result    | empty / pop       | o_result_kind ... o_empty_input
//  config    | i_cfg_we          | i_cfg_addr, i_cfg_data
//
// The parser takes one byte per cycle while full is low; a byte makes zero to
// four result items, kept as one bundle in a four-deep queue.
// Results leave one per cycle while pop is held; a byte's bundle holds the
// head until all are taken; full rises only when the queue holds four bundles.
// Synchronous reset restores all state but the bundle storage; no clearing pass.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_run_length,
    output logic        o_run_overflow,
    output logic [8:0]  o_field_count,
    output logic [8:0]  o_header_columns,
    output logic        o_width_mismatch,
    output logic [23:0] o_line_number,
    output logic [23:0] o_rows_kept,
    output logic        o_all_good,
    output logic        o_empty_input
);
    import cst_pkg::*;

    t_bnd  bnd;
    t_res  res;
    logic  bnd_wr;
    logic  q_full;

    // parser
    cst_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (push && !q_full),
        .i_kind     (i_kind),
        .i_in_byte  (i_in_byte),
        .o_bnd      (bnd),
        .o_bnd_wr   (bnd_wr)
    );

    // result queue
    cst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bnd   (bnd),
        .i_wr    (bnd_wr),
        .o_full  (q_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign full             = q_full;
    assign o_result_kind    = res.kind;
    assign o_out_byte       = res.data;
    assign o_run_length     = res.run;
    assign o_run_overflow   = res.ovf;
    assign o_field_count    = res.fc;
    assign o_header_columns = res.hdr;
    assign o_width_mismatch = res.mism;
    assign o_line_number    = res.line;
    assign o_rows_kept      = res.rows;
    assign o_all_good       = res.good;
    assign o_empty_input    = res.empty_in;

endmodule

// File: hw/rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks for the csv stream tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_result_kind,
    input logic [8:0]  o_field_count,
    input logic        o_width_mismatch,
    input logic [23:0] o_line_number,
    input logic        o_all_good,
    input logic        o_empty_input
);
    import cst_pkg::*;

    // a waiting item stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result item dropped while waiting");

    // a waiting item keeps its kind
    a_kind_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_result_kind))
        else $error("result kind changed while waiting");

    // status bits only on the final item
    a_final_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind != K_FINAL |-> !o_all_good && !o_empty_input)
        else $error("status bits outside final item");

    // width fields only on a record end
    a_rec_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind != K_RECORD_END |-> o_field_count == '0 &&
        !o_width_mismatch)
        else $error("record width outside record end");

    // line numbers are never zero; they start at one
    a_line_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_line_number != '0)
        else $error("line number zero");

endmodule

bind csv_stream_tokenizer_unit cst_checker u_cst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_result_kind    (o_result_kind),
    .o_field_count    (o_field_count),
    .o_width_mismatch (o_width_mismatch),
    .o_line_number    (o_line_number),
    .o_all_good       (o_all_good),
    .o_empty_input    (o_empty_input)
);

// File: bench/csv_stream_tokenizer_unit_test.sv
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_unit_test
// Self-checking bench for the csv tokenizer: a directed table of text bytes
// followed by random CSV-like lines and halting cases, with an item-level
// model predicting every result item and a scoreboard comparing them in order.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_unit_test;
    import cst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_data;
    logic        push;
    logic        full;
    logic        i_kind;
    logic [7:0]  i_in_byte;
    logic        empty;
    logic        pop;
    logic [2:0]  o_result_kind;
    logic [7:0]  o_out_byte;
    logic [15:0] o_run_length;
    logic        o_run_overflow;
    logic [8:0]  o_field_count;
    logic [8:0]  o_header_columns;
    logic        o_width_mismatch;
    logic [23:0] o_line_number;
    logic [23:0] o_rows_kept;
    logic        o_all_good;
    logic        o_empty_input;

    csv_stream_tokenizer_unit dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // one row of the directed table; chk means its first predicted result is checked
    typedef struct {
        logic       kind;
        logic [7:0] ch;
        logic       chk;
        t_kind      rkind;
        logic [7:0] rbyte;
    } t_row;

    // tokenizer shadow state
    logic [7:0]  sep_char, cmt_char;
    t_mode       mode;
    logic [15:0] spaces;
    logic        spaces_lost, drop_row, field_nonempty, saw_byte, good;
    logic [8:0]  row_fields, hdr_fields;
    logic [23:0] line_no, rows_kept;

    // expected_q waits for the scoreboard, typed_q keeps every predicted item
    t_res expected_q[$];
    t_res typed_q[$];
    int   mismatches;
    int   idle_cycles;
    bit   quiet;

    function automatic void emit(t_kind k, logic [7:0] b = 8'h00, logic [15:0] run = 0,
                                 logic ovf = 0, logic [8:0] fc = 0, logic mm = 0,
                                 logic ag = 0, logic ei = 0);
        t_res r;
        r.kind = k; r.data = b; r.run = run; r.ovf = ovf; r.fc = fc;
        r.hdr = hdr_fields; r.mism = mm; r.line = line_no; r.rows = rows_kept;
        r.good = ag; r.empty_in = ei;
        expected_q = {expected_q, r};
        typed_q = {typed_q, r};
    endfunction

    function automatic void reset_model();
        sep_char = SEP_RESET; cmt_char = COMMENT_RESET; mode = M_LINE;
        spaces = 0; spaces_lost = 0; drop_row = 0; field_nonempty = 0;
        row_fields = 0; hdr_fields = 0; line_no = 1; rows_kept = 0;
        good = 1; saw_byte = 0;
    endfunction

    function automatic void add_field_byte(logic [7:0] b);
        field_nonempty = 1;
        if (!drop_row) emit(K_FIELD_BYTE, b);
    endfunction

    function automatic void close_field();
        if (row_fields == 0) drop_row = !field_nonempty;
        if (!drop_row) emit(K_FIELD_END);
        if (row_fields < MAX_COLUMNS) row_fields++;
        field_nonempty = 0;
    endfunction

    function automatic void close_record();
        logic mm;
        mm = 0;
        if (drop_row) begin
            emit(K_ROW_DROPPED);
        end else begin
            if (hdr_fields == 0) hdr_fields = row_fields;
            else if (row_fields != hdr_fields) begin
                mm = 1;
                good = 0;
            end
            if (rows_kept < COUNT_MAX) rows_kept++;
            emit(K_RECORD_END, 8'h00, 0, 0, row_fields, mm);
        end
        row_fields = 0; drop_row = 0; field_nonempty = 0;
    endfunction

    function automatic void halt_parse();
        good = 0;
        emit(K_ABORT);
        mode = M_HALT;
    endfunction

    function automatic void next_line();
        if (line_no < COUNT_MAX) line_no++;
        mode = M_LINE;
    endfunction

    function automatic void after_close(logic [7:0] b);
        if (b == sep_char) mode = M_FSTART;
        else if (b == CH_LF) begin
            close_record();
            next_line();
        end else if (b == CH_CR) begin
            close_record();
            mode = M_WANT_LF;
        end else begin
            close_record();
            halt_parse();
        end
    endfunction

    function automatic bit is_text(logic [7:0] b);
        return b != sep_char && b >= CH_SPACE && b <= CH_TEXT_HIGH;
    endfunction

    function automatic void open_field(logic [7:0] b);
        if (b == sep_char) begin
            close_field();
            after_close(b);
        end else if (b == CH_QUOTE) mode = M_QUOTED;
        else if (is_text(b)) begin
            add_field_byte(b);
            mode = M_PLAIN;
        end else begin
            close_field();
            after_close(b);
        end
    endfunction

    function automatic void plain_step(logic [7:0] b);
        if (is_text(b)) add_field_byte(b);
        else begin
            close_field();
            after_close(b);
        end
    endfunction

    function automatic void release_spaces();
        if (spaces > 0) begin
            if (sep_char == CH_SPACE) begin
                drop_row = 1;
                row_fields = 1;
                mode = M_FSTART;
            end else begin
                emit(K_SPACE_RUN, 8'h00, spaces, spaces_lost);
                field_nonempty = 1;
                mode = M_PLAIN;
            end
        end else mode = M_FSTART;
        spaces = 0;
        spaces_lost = 0;
    endfunction

    // advance the shadow tokenizer by one accepted item
    function automatic void tokenize(logic kind, logic [7:0] b);
        if (kind == IN_END) begin
            case (mode)
                M_SPACES: begin
                    release_spaces();
                    close_field();
                    close_record();
                end
                M_FSTART, M_PLAIN, M_QUOTED, M_QCLOSE, M_ESCAPE: begin
                    close_field();
                    close_record();
                end
                M_AFTER: close_record();
                M_WANT_LF: halt_parse();
                default: ;
            endcase
            emit(K_FINAL, 8'h00, 0, 0, 0, 0, good, !saw_byte);
            mode = M_HALT;
            return;
        end
        saw_byte = 1;
        case (mode)
            M_LINE, M_SPACES: begin
                if (b == CH_SPACE) begin
                    if (spaces < SPACE_RUN_MAX) spaces++;
                    else spaces_lost = 1;
                    mode = M_SPACES;
                end else if (b == cmt_char) begin
                    spaces = 0;
                    spaces_lost = 0;
                    emit(K_COMMENT);
                    if (b == CH_LF) next_line();
                    else mode = M_COMMENT;
                end else begin
                    release_spaces();
                    if (mode == M_PLAIN) plain_step(b);
                    else open_field(b);
                end
            end
            M_COMMENT: if (b == CH_LF) next_line();
            M_FSTART: open_field(b);
            M_PLAIN: plain_step(b);
            M_QUOTED: begin
                if (b == CH_QUOTE) mode = M_QCLOSE;
                else if (b == CH_BACKSLASH) mode = M_ESCAPE;
                else if ((b >= CH_SPACE && b <= CH_TEXT_HIGH) || b == sep_char ||
                         b == CH_CR || b == CH_LF) add_field_byte(b);
                else begin
                    close_field();
                    mode = M_AFTER;
                end
            end
            M_QCLOSE: begin
                if (b == CH_QUOTE) begin
                    add_field_byte(CH_QUOTE);
                    mode = M_QUOTED;
                end else begin
                    close_field();
                    after_close(b);
                end
            end
            M_ESCAPE: begin
                add_field_byte(b);
                mode = M_QUOTED;
            end
            M_AFTER: after_close(b);
            M_WANT_LF: if (b == CH_LF) next_line(); else halt_parse();
            default: ;
        endcase
    endfunction

    // result side: random pop stalls, in-order compare
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && pop && !empty) begin
            got.kind = t_kind'(o_result_kind); got.data = o_out_byte;
            got.run = o_run_length; got.ovf = o_run_overflow; got.fc = o_field_count;
            got.hdr = o_header_columns; got.mism = o_width_mismatch;
            got.line = o_line_number; got.rows = o_rows_kept; got.good = o_all_good;
            got.empty_in = o_empty_input;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int stall;
        if (!i_rst_n) pop <= 1'b0;
        else if (quiet || $urandom_range(0, 5) != 0) pop <= 1'b1;
        else begin
            stall = $urandom_range(1, 12);
            pop <= 1'b0;
            repeat (stall - 1) @(negedge i_clk);
        end
    end

    // watchdog: cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("csv_stream_tokenizer_unit test failed");
            $finish;
        end
    end

    // send one item, waiting for the queue to accept it
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tokenize(kind, b);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_SEPARATOR) sep_char = val;
        else cmt_char = val;
    endtask

    // fresh document: the block halts after end of input, so restart with a reset
    // is not allowed; a single document run ends at the first end of input,
    // and later end items just give final status again

    function automatic logic [7:0] rand_text();
        case ($urandom_range(0, 9))
            0: return CH_QUOTE;
            1: return CH_BACKSLASH;
            2: return CH_SPACE;
            3: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic send_line(input int nf);
        int n;
        logic [7:0] c;
        for (int f = 0; f < nf; f++) begin
            if (f > 0) send_item(IN_DATA, sep_char);
            n = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) begin
                send_item(IN_DATA, CH_QUOTE);
                for (int k = 0; k < n; k++) begin
                    c = rand_text();
                    if (c == CH_QUOTE && $urandom_range(0, 1)) send_item(IN_DATA, CH_QUOTE);
                    send_item(IN_DATA, c);
                end
                send_item(IN_DATA, CH_QUOTE);
            end else begin
                for (int k = 0; k < n; k++) begin
                    c = 8'($urandom_range(8'h21, 8'h7E));
                    if (c != sep_char && c != cmt_char) send_item(IN_DATA, c);
                end
            end
        end
        if ($urandom_range(0, 3) == 0) send_item(IN_DATA, CH_CR);
        send_item(IN_DATA, CH_LF);
    endtask

    t_row dir_rows[$];

    function automatic void add_row(logic kind, logic [7:0] ch, logic chk = 0,
                                    t_kind rk = K_FIELD_BYTE, logic [7:0] rb = 0);
        t_row r;
        r.kind = kind; r.ch = ch; r.chk = chk; r.rkind = rk; r.rbyte = rb;
        dir_rows = {dir_rows, r};
    endfunction

    initial begin
        int nitems;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_addr = 1'b0; i_cfg_data = 8'h00;
        push = 1'b0; i_kind = IN_DATA; i_in_byte = 8'h00;
        mismatches = 0; idle_cycles = 0; quiet = 0;
        reset_model();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: comment line, field extremes, escapes, space run, width mismatch
        write_reg(CFG_SEPARATOR, 8'h2C);
        write_reg(CFG_COMMENT, 8'h23);
        add_row(IN_DATA, 8'h20);
        add_row(IN_DATA, 8'h23, 1, K_COMMENT);
        add_row(IN_DATA, 8'hFF);
        add_row(IN_DATA, CH_LF);
        add_row(IN_DATA, 8'h7E, 1, K_FIELD_BYTE, 8'h7E);
        add_row(IN_DATA, 8'h2C, 1, K_FIELD_END);
        add_row(IN_DATA, CH_QUOTE);
        add_row(IN_DATA, CH_BACKSLASH);
        add_row(IN_DATA, 8'h00, 1, K_FIELD_BYTE, 8'h00);
        add_row(IN_DATA, CH_QUOTE);
        add_row(IN_DATA, CH_QUOTE, 1, K_FIELD_BYTE, CH_QUOTE);
        add_row(IN_DATA, 8'h0A);
        add_row(IN_DATA, CH_QUOTE);
        add_row(IN_DATA, 8'h2C, 1, K_FIELD_END);
        add_row(IN_DATA, CH_CR);
        add_row(IN_DATA, CH_LF);
        add_row(IN_DATA, 8'h20);
        add_row(IN_DATA, 8'h20);
        add_row(IN_DATA, 8'h41, 1, K_SPACE_RUN);
        add_row(IN_DATA, CH_QUOTE);
        add_row(IN_DATA, CH_CR);
        add_row(IN_DATA, CH_LF);
        foreach (dir_rows[i]) begin
            nitems = typed_q.size();
            send_item(dir_rows[i].kind, dir_rows[i].ch);
            if (dir_rows[i].chk && (typed_q.size() <= nitems ||
                    typed_q[nitems].kind != dir_rows[i].rkind ||
                    typed_q[nitems].data != dir_rows[i].rbyte)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: expected kind %0d byte %h", i,
                             dir_rows[i].rkind, dir_rows[i].rbyte);
            end
        end

        // random lines, with separator and comment settings changed between phases
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin write_reg(CFG_SEPARATOR, 8'h3B); write_reg(CFG_COMMENT, 8'h21); end
                1: begin write_reg(CFG_SEPARATOR, 8'hFF); write_reg(CFG_COMMENT, 8'h00); end
                2: begin write_reg(CFG_SEPARATOR, 8'h09); write_reg(CFG_COMMENT, 8'hFF); end
                default: begin
                    write_reg(CFG_SEPARATOR, 8'h2C);
                    write_reg(CFG_COMMENT, 8'h23);
                    quiet = 1;
                end
            endcase
            for (int l = 0; l < 8; l++) begin
                case ($urandom_range(0, 9))
                    0: begin send_item(IN_DATA, cmt_char); send_item(IN_DATA, 8'h41);
                             send_item(IN_DATA, CH_LF); end
                    1: begin send_item(IN_DATA, sep_char); send_item(IN_DATA, CH_LF); end
                    2: begin send_item(IN_DATA, CH_SPACE); send_line(2); end
                    default: send_line($urandom_range(1, 3));
                endcase
            end
        end

        // halting cases: space separator, a stray CR and end of input
        drain();
        write_reg(CFG_SEPARATOR, CH_SPACE);
        write_reg(CFG_COMMENT, CH_LF);
        send_item(IN_DATA, CH_LF);
        send_item(IN_DATA, CH_SPACE);
        send_item(IN_DATA, 8'h42);
        send_item(IN_DATA, CH_LF);
        send_item(IN_DATA, 8'h43);
        send_item(IN_DATA, CH_CR);
        send_item(IN_DATA, 8'h44);
        send_item(IN_DATA, 8'h45);
        send_item(IN_END, 8'hA5);
        send_item(IN_END, 8'h00);
        push <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) $display("csv_stream_tokenizer_unit test passed");
        else $display("csv_stream_tokenizer_unit test failed");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/cst_pkg.sv
hw/rtl/cst_front.sv
hw/rtl/cst_queue.sv
hw/rtl/csv_stream_tokenizer_unit.sv
hw/rtl/cst_checker.sv
bench/csv_stream_tokenizer_unit_test.sv
